[rtl/core/rgbrf_pkg.sv]
// Shared types, constants and helpers for the RGB LED driver register file.
// No dependencies; every module of the block imports this package.
package rgbrf_pkg;

    localparam int REG_COUNT_DEF = 16;
    localparam int CHAN_COUNT    = 3;

    // Register map
    localparam int IDX_MODE1   = 0;
    localparam int IDX_PWM0    = 2;
    localparam int IDX_GRPPWM  = 6;
    localparam int IDX_GRPFREQ = 7;
    localparam int IDX_LEDOUT  = 8;

    localparam int MODE1_SLEEP_BIT   = 4;
    localparam int MODE1_AUTOINC_BIT = 5;

    localparam logic [7:0] GRPPWM_RST  = 8'hFF;
    localparam logic [7:0] GRPFREQ_RST = 8'h1F;
    localparam logic [7:0] LEVEL_FULL  = 8'd255;
    localparam logic [7:0] LEVEL_MAX   = 8'd254;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_END   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        LED_OFF  = 2'd0,
        LED_FULL = 2'd1,
        LED_PWM  = 2'd2,
        LED_GRP  = 2'd3
    } led_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CALC,
        ST_STORE,
        ST_OUT
    } state_t;

    // Registers that the level calculation reads at fixed places
    typedef struct packed {
        logic [7:0]      mode1;
        logic [2:0][7:0] pwm;
        logic [7:0]      grppwm;
        logic [7:0]      ledout;
    } shadow_t;

    // One request to the shared level unit
    typedef struct packed {
        logic       start;
        logic       sleep;
        led_sel_t   sel;
        logic [7:0] pwm;
        logic [7:0] grp;
    } lvl_req_t;

    function automatic logic [7:0] reg_reset_value(input logic [7:0] idx);
        logic [7:0] val;
        val = 8'd0;
        if (idx == 8'(IDX_GRPPWM)) begin
            val = GRPPWM_RST;
        end else if (idx == 8'(IDX_GRPFREQ)) begin
            val = GRPFREQ_RST;
        end
        return val;
    endfunction

endpackage

[rtl/core/rgbrf_regfile.sv]
// Register file storage: one-write, one-read memory with per-entry valid bits,
// plus flip-flop copies of the registers the level logic needs. Uses rgbrf_pkg.
module rgbrf_regfile #(
    parameter int REG_COUNT = rgbrf_pkg::REG_COUNT_DEF,
    localparam int PTR_W    = $clog2(REG_COUNT)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  logic [PTR_W-1:0]        wr_addr,
    input  logic [7:0]              wr_data,
    input  logic [PTR_W-1:0]        rd_addr,
    output logic [7:0]              rd_data,
    output rgbrf_pkg::shadow_t      shadow
);
    import rgbrf_pkg::*;

    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic                 hit_reg;
    logic [7:0]           dflt_reg;
    shadow_t              shadow_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
        dflt_reg  <= reg_reset_value(8'(rd_addr));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg         <= '0;
            hit_reg           <= 1'b0;
            shadow_reg.mode1  <= 8'd0;
            shadow_reg.pwm    <= '0;
            shadow_reg.grppwm <= GRPPWM_RST;
            shadow_reg.ledout <= 8'd0;
        end else begin
            hit_reg <= valid_reg[rd_addr];
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
                if (wr_addr == PTR_W'(IDX_MODE1))  shadow_reg.mode1  <= wr_data;
                if (wr_addr == PTR_W'(IDX_PWM0))   shadow_reg.pwm[0] <= wr_data;
                if (wr_addr == PTR_W'(IDX_PWM0+1)) shadow_reg.pwm[1] <= wr_data;
                if (wr_addr == PTR_W'(IDX_PWM0+2)) shadow_reg.pwm[2] <= wr_data;
                if (wr_addr == PTR_W'(IDX_GRPPWM)) shadow_reg.grppwm <= wr_data;
                if (wr_addr == PTR_W'(IDX_LEDOUT)) shadow_reg.ledout <= wr_data;
            end
        end
    end

    // Unwritten entries read as their reset value
    assign rd_data = hit_reg ? mem_q_reg : dflt_reg;
    assign shadow  = shadow_reg;

endmodule

[rtl/core/rgbrf_level_unit.sv]
// Shared channel level unit: one 8x8 product, selection and clamp per request;
// the result is registered. Uses rgbrf_pkg.
module rgbrf_level_unit (
    input  logic                aclk,
    input  rgbrf_pkg::lvl_req_t req,
    output logic [7:0]          level
);
    import rgbrf_pkg::*;

    logic [15:0] prod;
    logic [7:0]  level_next;
    logic [7:0]  level_reg;

    assign prod = req.pwm * req.grp;

    always_comb begin
        level_next = 8'd0;
        if (!req.sleep) begin
            case (req.sel)
                LED_OFF:  level_next = 8'd0;
                LED_FULL: level_next = LEVEL_FULL;
                LED_PWM:  level_next = req.pwm;
                LED_GRP:  level_next = prod[15:8];
                default:  level_next = 8'd0;
            endcase
        end
        if (level_next > LEVEL_MAX) begin
            level_next = LEVEL_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

[rtl/core/rgbrf_top.sv]
// Sequencer for the RGB LED driver register file: decodes bus events, drives
// the register file and steps the shared level unit over the three channels.
// Uses rgbrf_pkg, rgbrf_regfile and rgbrf_level_unit.
module rgbrf_top #(
    parameter int REG_COUNT = rgbrf_pkg::REG_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[1:0], data_byte[9:2], byte_count[17:10], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_data, red_compare, green_compare, blue_compare
);
    import rgbrf_pkg::*;

    localparam int PTR_W = $clog2(REG_COUNT);

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [7:0]          data_reg, data_next;
    logic [7:0]          count_reg, count_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [PTR_W-1:0]    left_reg, left_next;
    logic                open_reg, open_next;
    logic [1:0]          chan_reg, chan_next;
    logic [2:0][7:0]     lvl_reg, lvl_next;
    logic [7:0]          rd_reg, rd_next;

    logic                wr_en;
    logic [7:0]          rd_data;
    shadow_t             shadow;
    lvl_req_t            req;
    logic [7:0]          level;
    logic                autoinc;
    logic                autoinc_wr;
    logic [PTR_W-1:0]    ptr_inc;

    rgbrf_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (data_reg),
        .rd_addr (ptr_reg),
        .rd_data (rd_data),
        .shadow  (shadow)
    );

    rgbrf_level_unit u_level (
        .aclk  (aclk),
        .req   (req),
        .level (level)
    );

    assign autoinc = shadow.mode1[MODE1_AUTOINC_BIT];
    // A data write into MODE1 already governs the pointer step that follows it
    assign autoinc_wr = (ptr_reg == PTR_W'(IDX_MODE1)) ? data_reg[MODE1_AUTOINC_BIT]
                                                       : autoinc;
    assign ptr_inc = (ptr_reg == PTR_W'(REG_COUNT - 1)) ? '0 : ptr_reg + 1'b1;

    always_comb begin
        req.start = (state_reg == ST_CALC);
        req.sleep = shadow.mode1[MODE1_SLEEP_BIT];
        req.sel   = led_sel_t'(shadow.ledout[{chan_reg, 1'b0} +: 2]);
        req.pwm   = shadow.pwm[chan_reg];
        req.grp   = shadow.grppwm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            left_reg  <= '0;
            open_reg  <= 1'b0;
            chan_reg  <= 2'd0;
            lvl_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            left_reg  <= left_next;
            open_reg  <= open_next;
            chan_reg  <= chan_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        data_reg  <= data_next;
        count_reg <= count_next;
        rd_reg    <= rd_next;
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        data_next  = data_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        open_next  = open_reg;
        chan_next  = chan_reg;
        lvl_next   = lvl_reg;
        rd_next    = rd_reg;
        wr_en      = 1'b0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mode_next  = mode_t'(s_tdata[1:0]);
                    data_next  = s_tdata[9:2];
                    count_next = s_tdata[17:10];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                rd_next    = 8'd0;
                state_next = ST_OUT;
                case (mode_reg)
                    MODE_START: begin
                        if (count_reg == 8'd0 || count_reg > 8'(REG_COUNT)) begin
                            open_next = 1'b0;
                            left_next = '0;
                        end else begin
                            open_next = 1'b1;
                            left_next = PTR_W'(count_reg - 8'd1);
                            ptr_next  = (data_reg >= 8'(REG_COUNT)) ? '0
                                                                    : data_reg[PTR_W-1:0];
                        end
                    end
                    MODE_DATA: begin
                        if (open_reg && left_reg != '0) begin
                            wr_en     = 1'b1;
                            left_next = left_reg - 1'b1;
                            if (autoinc_wr) ptr_next = ptr_inc;
                        end
                    end
                    MODE_READ: begin
                        rd_next = rd_data;
                        if (autoinc) ptr_next = ptr_inc;
                    end
                    MODE_END: begin
                        open_next = 1'b0;
                        left_next = '0;
                        if (open_reg) begin
                            chan_next  = 2'd0;
                            state_next = ST_CALC;
                        end
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_CALC: begin
                state_next = ST_STORE;
            end
            ST_STORE: begin
                lvl_next[chan_reg] = level;
                if (chan_reg == 2'(CHAN_COUNT - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = ST_CALC;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Compare value is 255 minus level
    assign m_tdata = {~lvl_reg[2], ~lvl_reg[1], ~lvl_reg[0], rd_reg};

endmodule

[rtl/core/rgb_led_driver_register_file_top.sv]
// Top level of the RGB LED driver register file.
// Operation: a write start, data write, read or idle write end is executed and its
// result offered on the output; a write end that recomputes the channels first has
// the shared level unit serve the three channels in turn, computing, then storing each.
// A new transfer is accepted only after the output of the last one has been taken.
// Reset: aresetn (synchronous, active low) clears control state and the valid bits
// of the register file, so it reads as its reset contents at once; no clearing pass.
module rgb_led_driver_register_file_top #(
    parameter int REG_COUNT = rgbrf_pkg::REG_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[1:0], data_byte[9:2], byte_count[17:10], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_data[7:0], red[15:8], green[23:16], blue[31:24]
);
    import rgbrf_pkg::*;

    logic [7:0] s_mode_pad;
    logic       s_tvalid_q;

    // Zero-pad the mode field and pass valid on only while its upper bits are zero
    assign s_mode_pad = {6'd0, s_tdata[1:0]};
    assign s_tvalid_q = s_tvalid && (s_mode_pad[7:2] == 6'd0);

    rgbrf_top #(
        .REG_COUNT (REG_COUNT)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid_q),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
